@@ design/olie_pkg.sv @@
// Shared types and constants for the ordered list insert/delete engine.
// Depends on nothing; every other design file imports it.
`default_nettype none

package olie_pkg;

  localparam int OP_W    = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2,
    OP_LIST       = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

`default_nettype wire

@@ design/olie_in_if.sv @@
// Operation channel: valid/ready handshake carrying one operation beat.
// Depends on olie_pkg.
`default_nettype none

interface olie_in_if;
  import olie_pkg::*;

  logic                      valid;
  logic                      ready;
  op_t                       operation;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

@@ design/olie_out_if.sv @@
// Result channel: valid/ready handshake carrying one result beat.
// Depends on olie_pkg.
`default_nettype none

interface olie_out_if;
  import olie_pkg::*;

  logic                      valid;
  logic                      ready;
  status_t                   status;
  logic signed [VALUE_W-1:0] element;
  logic                      last_of_run;
  logic [TOTAL_W-1:0]        entry_total;

  modport source (output valid, output status, output element, output last_of_run,
                  output entry_total, input ready);
  modport sink   (input valid, input status, input element, input last_of_run,
                  input entry_total, output ready);
endinterface

`default_nettype wire

@@ design/ordered_list_insert_delete_engine.sv @@
// Ordered list engine over a circular store of CAPACITY signed 32-bit entries.
// Operations: insert writes the store and loads the result register via S_OUT; delete searches
//   from the front for the match, then shifts the entries behind it down one place, or
//   reports not found after the last entry; list gives one beat per cycle while the sink accepts.
// Throughput: one operation at a time; ready only while the sequencer is idle.
// Reset: synchronous active-low rst_n empties the list; store contents are left as is.
`default_nettype none

module ordered_list_insert_delete_engine #(
  parameter int CAPACITY = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  olie_in_if.sink        in_bus,
  olie_out_if.source     out_bus
);
  import olie_pkg::*;

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int OFF_W = CNT_W + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_LIST   = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  // sequencer and list bookkeeping
  state_t                    state_r, state_nxt;
  logic [PTR_W-1:0]          front_r, front_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  status_t                   pstat_r, pstat_nxt;

  // entry store, one write and one registered read port
  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rdata_r;
  logic                      mem_we;
  logic [PTR_W-1:0]          waddr;
  logic [PTR_W-1:0]          raddr;
  logic signed [VALUE_W-1:0] wdata;

  // result register
  logic                      out_valid_r;
  status_t                   out_status_r;
  logic signed [VALUE_W-1:0] out_element_r;
  logic                      out_last_r;
  logic [TOTAL_W-1:0]        out_total_r;

  logic                      emit;
  status_t                   e_status;
  logic signed [VALUE_W-1:0] e_elem;
  logic                      e_last;

  logic                      in_fire;
  logic                      out_free;
  logic [OFF_W-1:0]          idx_p1;
  logic [OFF_W-1:0]          idx_p2;
  logic [OFF_W-1:0]          cnt_ext;
  logic [PTR_W-1:0]          front_dec;
  logic [CNT_W+TOTAL_W-1:0]  total_wide;

  // Map a list offset (0 = front) to its store slot; offset never exceeds CAPACITY.
  function automatic logic [PTR_W-1:0] slot_of(input logic [OFF_W-1:0] off);
    logic [OFF_W:0] sum;
    sum = (OFF_W+1)'(front_r) + (OFF_W+1)'(off);
    if (sum >= (OFF_W+1)'(CAPACITY)) begin
      sum = sum - (OFF_W+1)'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire      = in_bus.valid && (state_r == S_IDLE);
  // The result register may be loaded when empty or being drained this cycle.
  assign out_free     = !out_valid_r || out_bus.ready;

  assign idx_p1     = OFF_W'(idx_r) + OFF_W'(1);
  assign idx_p2     = OFF_W'(idx_r) + OFF_W'(2);
  assign cnt_ext    = OFF_W'(count_r);
  assign front_dec  = (front_r == '0) ? PTR_W'(CAPACITY - 1) : front_r - 1'b1;
  assign total_wide = {{TOTAL_W{1'b0}}, count_r};

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    pstat_nxt = pstat_r;
    mem_we    = 1'b0;
    waddr     = front_r;
    wdata     = in_bus.value;
    raddr     = front_r;
    emit      = 1'b0;
    e_status  = ST_OK;
    e_elem    = val_r;
    e_last    = 1'b1;

    case (state_r)
      S_IDLE: begin
        // Read the front entry now so search and list have it next cycle.
        raddr = front_r;
        if (in_fire) begin
          val_nxt = in_bus.value;
          case (in_bus.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              state_nxt = S_OUT;
              if (count_r == CNT_W'(CAPACITY)) begin
                pstat_nxt = ST_FULL;
              end else begin
                pstat_nxt = ST_OK;
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
                if (in_bus.operation == OP_PUSH_FRONT) begin
                  front_nxt = front_dec;
                  waddr     = front_dec;
                end else begin
                  waddr = slot_of(cnt_ext);
                end
              end
            end
            OP_DELETE: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                pstat_nxt = ST_EMPTY;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            OP_LIST: begin
              idx_nxt = '0;
              if (count_r == '0) begin
                pstat_nxt = ST_EMPTY;
                val_nxt   = '0;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_LIST;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        // rdata_r holds entry idx_r; prefetch the next one.
        raddr = slot_of(idx_p1);
        if (rdata_r == val_r) begin
          if (idx_p1 == cnt_ext) begin
            // match is the back entry: nothing to close up
            count_nxt = count_r - 1'b1;
            if (count_r == CNT_W'(1)) begin
              front_nxt = '0;
            end
            pstat_nxt = ST_OK;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (idx_p1 == cnt_ext) begin
          pstat_nxt = ST_NOT_FOUND;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_SHIFT: begin
        // rdata_r holds entry idx_r+1; move it down one place.
        mem_we = 1'b1;
        waddr  = slot_of(OFF_W'(idx_r));
        wdata  = rdata_r;
        raddr  = slot_of(idx_p2);
        if (idx_p2 == cnt_ext) begin
          count_nxt = count_r - 1'b1;
          pstat_nxt = ST_OK;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_LIST: begin
        if (out_free) begin
          emit     = 1'b1;
          e_status = ST_OK;
          e_elem   = rdata_r;
          e_last   = (idx_p1 == cnt_ext);
          raddr    = slot_of(idx_p1);
          if (idx_p1 == cnt_ext) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          // hold: re-read the same entry while the sink stalls
          raddr = slot_of(OFF_W'(idx_r));
        end
      end

      S_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          e_status  = pstat_r;
          e_elem    = val_r;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    pstat_r <= pstat_nxt;
    if (emit) begin
      out_status_r  <= e_status;
      out_element_r <= e_elem;
      out_last_r    <= e_last;
      out_total_r   <= total_wide[TOTAL_W-1:0];
    end
  end

  // entry store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.status      = out_status_r;
  assign out_bus.element     = out_element_r;
  assign out_bus.last_of_run = out_last_r;
  assign out_bus.entry_total = out_total_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(count_r) |->
      $past(in_fire) || $past(state_r == S_SEARCH) || $past(state_r == S_SHIFT))
    else $error("entry count changed outside insert or delete");

  a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_last_r)
    else $error("error result not marked last");

  a_list_total: assert property (@(posedge clk) disable iff (!rst_n)
    emit && (state_r == S_LIST) |=> out_total_r == total_wide[TOTAL_W-1:0])
    else $error("list beat total does not match entry count");
`endif

endmodule

`default_nettype wire
